// ===== rtl/qte_pkg.sv =====
// Shared types, constants and the arctangent table for the quaternion-to-Euler core.
package qte_pkg;

  localparam int unsigned CORDIC_STEPS = 20;  // 12..32

  localparam int QW     = 32;  // Q2.30 component width
  localparam int AccW   = 38;  // product sums
  localparam int OpW    = 42;  // CORDIC x/y datapath
  localparam int AngW   = 34;  // angle, Q.30 radians
  localparam int ScaleW = 49;  // angle times centidegree scale
  localparam int IterW  = 5;   // index into the 32-entry table

  localparam logic signed [AngW-1:0] HalfPi     = 34'sd1686629713;
  localparam logic signed [14:0]     CentiScale = 15'sd5730;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic                  start;
    logic signed [OpW-1:0] y;
    logic signed [OpW-1:0] x;
  } cord_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [AngW-1:0] angle;
  } cord_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_CLAMP, B_SQ, B_ISQ_INIT, B_ISQ,
    B_CORD, B_CWAIT, B_SCALE, B_STORE, B_OUT
  } back_state_e;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_lut(logic [IterW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qte_if.sv =====
// Request channels: quaternion in, Euler angles out.
interface qte_quat_if (input logic clk_i);
  logic                  valid;
  logic                  ready;
  logic                  has_quaternion;
  logic signed [31:0]    quat_w;
  logic signed [31:0]    quat_x;
  logic signed [31:0]    quat_y;
  logic signed [31:0]    quat_z;
  modport source (output valid, has_quaternion, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink   (input valid, has_quaternion, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface qte_euler_if (input logic clk_i);
  logic                  valid;
  logic                  ready;
  logic signed [14:0]    pitch_centideg;
  logic signed [15:0]    roll_centideg;
  logic signed [15:0]    yaw_centideg;
  modport source (output valid, pitch_centideg, roll_centideg, yaw_centideg,
                  input ready);
  modport sink   (input valid, pitch_centideg, roll_centideg, yaw_centideg,
                  output ready);
endinterface

// ===== rtl/qte_front.sv =====
// Front end: takes requests, drops those without a quaternion, queues the rest.
module qte_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  qte_quat_if.sink       quat_i,
  input  logic           pop_i,
  output logic           head_valid_o,
  output qte_pkg::quat_t head_o
);
  import qte_pkg::*;

  quat_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign quat_i.ready = (cnt_q != 2'd2);
  assign push         = quat_i.valid && quat_i.ready && quat_i.has_quaternion;
  assign pop          = pop_i && (cnt_q != 2'd0);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{w: quat_i.quat_w, x: quat_i.quat_x,
                           y: quat_i.quat_y, z: quat_i.quat_z};
    end
  end

endmodule

// ===== rtl/qte_cordic.sv =====
// Vectoring CORDIC: atan2(y, x) in Q.30, one iteration per cycle.
module qte_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qte_pkg::cord_req_t  req_i,
  output qte_pkg::cord_rsp_t  rsp_o
);
  import qte_pkg::*;

  localparam logic [IterW-1:0] LastIter = IterW'(CORDIC_STEPS - 1);

  logic signed [OpW-1:0]  x_q, y_q, dx, dy;
  logic signed [AngW-1:0] z_q, at_s;
  logic [IterW-1:0]       i_q;
  logic                   busy_q, done_q, zero_q;

  assign dx   = y_q >>> i_q;
  assign dy   = x_q >>> i_q;
  assign at_s = signed'({2'b00, atan_lut(i_q)});

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = zero_q ? '0 : z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && (i_q == LastIter);
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == LastIter) busy_q <= 1'b0;
        else                 i_q    <= i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      zero_q <= (req_i.x == '0) && (req_i.y == '0);
      if (req_i.x < 0) begin
        if (req_i.y >= 0) begin
          x_q <= req_i.y;
          y_q <= -req_i.x;
          z_q <= HalfPi;
        end else begin
          x_q <= -req_i.y;
          y_q <= req_i.x;
          z_q <= -HalfPi;
        end
      end else begin
        x_q <= req_i.x;
        y_q <= req_i.y;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at_s;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at_s;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("cordic restarted while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("cordic done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("cordic done without work");

endmodule

// ===== rtl/qte_back.sv =====
// Back end: products, pitch clamp and square root, three CORDIC runs, scaling.
module qte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  qte_pkg::quat_t     head_i,
  output logic               pop_o,
  output qte_pkg::cord_req_t cord_req_o,
  input  qte_pkg::cord_rsp_t cord_rsp_i,
  qte_euler_if.source        euler_o
);
  import qte_pkg::*;

  localparam logic signed [AccW:0]  OneClamp = (AccW+1)'(64'sd1073741824);
  localparam logic signed [OpW-1:0] OneOp    = OpW'(64'sd1073741824);
  localparam logic [61:0]           SqTop    = 62'd1 << 60;
  localparam logic signed [ScaleW-1:0] RoundBias = ScaleW'(64'sd1073741823);

  back_state_e state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [4:0]  k_q, k_d;
  logic [1:0]  sel_q, sel_d;

  quat_t                    qt_q;
  logic signed [QW-1:0]     mul_a, mul_b, s_q;
  logic signed [63:0]       prod_d, prod_q;
  logic signed [33:0]       pfl;
  logic signed [AccW-1:0]   sacc_q, ry_q, rx_q, yy_q, yx_q, pext;
  logic signed [AccW:0]     s2;
  logic [61:0]              v_q, res_q, bitv, trial;
  logic signed [ScaleW-1:0] scl_q, sadj;
  logic signed [15:0]       field;
  logic signed [14:0]       pitch_q;
  logic signed [15:0]       roll_q;
  logic [3:0]               pidx;
  logic                     out_free, load_out;

  // shared 32x32 multiplier
  always_comb begin
    mul_a = s_q;
    mul_b = s_q;
    if (state_q == B_MUL) begin
      case (cnt_q)
        4'd0:    begin mul_a = qt_q.w; mul_b = qt_q.y; end
        4'd1:    begin mul_a = qt_q.x; mul_b = qt_q.z; end
        4'd2:    begin mul_a = qt_q.y; mul_b = qt_q.z; end
        4'd3:    begin mul_a = qt_q.w; mul_b = qt_q.x; end
        4'd4:    begin mul_a = qt_q.x; mul_b = qt_q.x; end
        4'd5:    begin mul_a = qt_q.y; mul_b = qt_q.y; end
        4'd6:    begin mul_a = qt_q.x; mul_b = qt_q.y; end
        4'd7:    begin mul_a = qt_q.w; mul_b = qt_q.z; end
        4'd8:    begin mul_a = qt_q.w; mul_b = qt_q.w; end
        default: begin mul_a = qt_q.z; mul_b = qt_q.z; end
      endcase
    end
  end
  assign prod_d = mul_a * mul_b;
  assign pfl    = 34'(prod_q >>> 30);
  assign pext   = AccW'(pfl);
  assign pidx   = cnt_q - 4'd1;

  assign s2    = (AccW+1)'(sacc_q) <<< 1;
  assign bitv  = SqTop >> {k_q, 1'b0};
  assign trial = res_q + bitv;
  assign sadj  = (scl_q < 0) ? scl_q + RoundBias : scl_q;
  assign field = 16'(sadj >>> 30);

  assign out_free = !euler_o.valid || euler_o.ready;
  assign load_out = (state_q == B_OUT) && out_free;
  assign pop_o    = (state_q == B_IDLE) && head_valid_i;

  // CORDIC operands for pitch, roll, yaw
  always_comb begin
    cord_req_o.start = (state_q == B_CORD);
    case (sel_q)
      2'd0: begin
        cord_req_o.y = OpW'(s_q);
        cord_req_o.x = OpW'(signed'({1'b0, res_q[30:0]}));
      end
      2'd1: begin
        cord_req_o.y = OpW'(ry_q) <<< 1;
        cord_req_o.x = OneOp - (OpW'(rx_q) <<< 1);
      end
      default: begin
        cord_req_o.y = OpW'(yy_q) <<< 1;
        cord_req_o.x = OpW'(yx_q);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    sel_d   = sel_q;
    unique case (state_q)
      B_IDLE: if (head_valid_i) begin
        state_d = B_MUL;
        cnt_d   = '0;
      end
      B_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd10) state_d = B_CLAMP;
      end
      B_CLAMP:    state_d = B_SQ;
      B_SQ:       state_d = B_ISQ_INIT;
      B_ISQ_INIT: begin
        state_d = B_ISQ;
        k_d     = '0;
      end
      B_ISQ: begin
        k_d = k_q + 5'd1;
        if (k_q == 5'd30) begin
          state_d = B_CORD;
          sel_d   = 2'd0;
        end
      end
      B_CORD:  state_d = B_CWAIT;
      B_CWAIT: if (cord_rsp_i.done) state_d = B_SCALE;
      B_SCALE: state_d = B_STORE;
      B_STORE: begin
        if (sel_q == 2'd2) state_d = B_OUT;
        else begin
          state_d = B_CORD;
          sel_d   = sel_q + 2'd1;
        end
      end
      B_OUT: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      cnt_q         <= '0;
      k_q           <= '0;
      sel_q         <= '0;
      euler_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      sel_q   <= sel_d;
      if (load_out)           euler_o.valid <= 1'b1;
      else if (euler_o.ready) euler_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (pop_o) begin
      qt_q   <= head_i;
      sacc_q <= '0;
      ry_q   <= '0;
      rx_q   <= '0;
      yy_q   <= '0;
      yx_q   <= '0;
    end
    if (state_q == B_MUL && cnt_q != 4'd0) begin
      case (pidx)
        4'd0: sacc_q <= sacc_q + pext;
        4'd1: sacc_q <= sacc_q - pext;
        4'd2, 4'd3: ry_q <= ry_q + pext;
        4'd4: begin rx_q <= rx_q + pext; yx_q <= yx_q + pext; end
        4'd5: begin rx_q <= rx_q + pext; yx_q <= yx_q - pext; end
        4'd6, 4'd7: yy_q <= yy_q + pext;
        4'd8: yx_q <= yx_q + pext;
        default: yx_q <= yx_q - pext;
      endcase
    end
    if (state_q == B_CLAMP) begin
      if (s2 > OneClamp)       s_q <= QW'(OneClamp);
      else if (s2 < -OneClamp) s_q <= QW'(-OneClamp);
      else                     s_q <= QW'(s2);
    end
    if (state_q == B_ISQ_INIT) begin
      v_q   <= SqTop - 62'(prod_q);
      res_q <= '0;
    end
    if (state_q == B_ISQ) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
    end
    if (state_q == B_SCALE) scl_q <= ScaleW'(cord_rsp_i.angle) * ScaleW'(CentiScale);
    if (state_q == B_STORE) begin
      case (sel_q)
        2'd0:    pitch_q <= field[14:0];
        2'd1:    roll_q  <= field;
        default: yx_q    <= yx_q;
      endcase
    end
    if (load_out) begin
      euler_o.pitch_centideg <= pitch_q;
      euler_o.roll_centideg  <= roll_q;
      euler_o.yaw_centideg   <= field;
    end
  end

endmodule

// ===== rtl/quaternion_to_euler_angles_core.sv =====
// Top level: quaternion (Q2.30) to Z-Y-X Euler angles in hundredths of a degree.
// Each request with has_quaternion set yields one result of pitch, roll and yaw
// (radians times 5730, truncated toward zero); a request with it clear is
// dropped and yields nothing. The front end takes a request in any cycle that
// its two-entry queue has room, so input and output stall independently. The
// back end handles one quaternion at a time and sets the rate: ten products on
// a shared 32x32 multiplier, the pitch clamp and its square, a bit-pair square
// root, then three runs of one shared CORDIC unit of CORDIC_STEPS iterations
// each.
// The asin argument 2(wy - xz) is clamped to [-1, 1]; the input is not
// normalized. No reset-time initialization pass is needed.
module quaternion_to_euler_angles_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  qte_quat_if.sink    quat_i,
  qte_euler_if.source euler_o
);
  import qte_pkg::*;

  logic      head_valid, pop;
  quat_t     head;
  cord_req_t cord_req;
  cord_rsp_t cord_rsp;

  // accept and queue requests
  qte_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quat_i       (quat_i),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // arithmetic sequencer with its own output register
  qte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .cord_req_o   (cord_req),
    .cord_rsp_i   (cord_rsp),
    .euler_o      (euler_o)
  );

  // shared arctangent unit
  qte_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cord_req),
    .rsp_o  (cord_rsp)
  );

endmodule

// ===== tb/qte_angle_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts Euler angles from accepted quaternion requests and compares.
module qte_angle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qte_quat_if.sink    quat_mon,
  qte_euler_if.sink   euler_mon,
  output int          fail_cnt_o,
  output int          pending_o
);
  import qte_pkg::*;

  localparam longint OneQ30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } euler_t;

  euler_t angles_q[$];
  int     fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = angles_q.size();

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fshift(a * b, 30);
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang;
    longint t;
    longint dx;
    longint dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = HalfPi;
      end else begin
        x = -y; y = t; ang = -HalfPi;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(atan_lut(i[IterW-1:0]));
      end else begin
        x -= dx; y += dy; ang -= longint'(atan_lut(i[IterW-1:0]));
      end
    end
    return ang;
  endfunction

  function automatic longint to_centideg(longint ang);
    return (ang * 5730) / OneQ30;  // truncates toward zero
  endfunction

  function automatic euler_t euler_from_quat(longint w, longint x, longint y, longint z);
    euler_t e;
    longint s;
    longint c;
    s = 2 * (qmul(w, y) - qmul(x, z));
    if (s > OneQ30) s = OneQ30;
    if (s < -OneQ30) s = -OneQ30;
    c = root_floor(OneQ30 * OneQ30 - s * s);
    e.pitch = 15'(to_centideg(vector_angle(s, c)));
    e.roll  = 16'(to_centideg(vector_angle(2 * (qmul(y, z) + qmul(w, x)),
                                           OneQ30 - 2 * (qmul(x, x) + qmul(y, y)))));
    e.yaw   = 16'(to_centideg(vector_angle(2 * (qmul(x, y) + qmul(w, z)),
                                           qmul(w, w) + qmul(x, x)
                                           - qmul(y, y) - qmul(z, z))));
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    euler_t exp_e;
    if (!rst_ni) begin
      fail_cnt = 0;
    end else begin
      if (quat_mon.valid && quat_mon.ready && quat_mon.has_quaternion)
        angles_q.push_back(euler_from_quat(quat_mon.quat_w, quat_mon.quat_x,
                                           quat_mon.quat_y, quat_mon.quat_z));
      if (euler_mon.valid && euler_mon.ready) begin
        if (angles_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result p=%0d r=%0d y=%0d", euler_mon.pitch_centideg,
                     euler_mon.roll_centideg, euler_mon.yaw_centideg);
        end else begin
          exp_e = angles_q.pop_front();
          if (exp_e.pitch !== euler_mon.pitch_centideg ||
              exp_e.roll !== euler_mon.roll_centideg ||
              exp_e.yaw !== euler_mon.yaw_centideg) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch exp p=%0d r=%0d y=%0d got p=%0d r=%0d y=%0d",
                       exp_e.pitch, exp_e.roll, exp_e.yaw, euler_mon.pitch_centideg,
                       euler_mon.roll_centideg, euler_mon.yaw_centideg);
          end
        end
      end
    end
  end
endmodule

// ===== tb/quaternion_to_euler_angles_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, quaternion stimulus, output stalls and verdict.
module quaternion_to_euler_angles_core_tb;
  localparam int RandItems = 2000;
  localparam int QuietTail = 300;   // last requests go without idling

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  bit   quiet;

  qte_quat_if  quat_ch  (.clk_i(clk_i));
  qte_euler_if euler_ch (.clk_i(clk_i));

  quaternion_to_euler_angles_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quat_i  (quat_ch.sink),
    .euler_o (euler_ch.source)
  );

  qte_angle_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .quat_mon   (quat_ch.sink),
    .euler_mon  (euler_ch.sink),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one request; optionally precede it with an idle burst.
  task automatic send_quat(bit hasq, logic [31:0] w, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      quat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    quat_ch.valid          <= 1'b1;
    quat_ch.has_quaternion <= hasq;
    quat_ch.quat_w         <= w;
    quat_ch.quat_x         <= x;
    quat_ch.quat_y         <= y;
    quat_ch.quat_z         <= z;
    do @(posedge clk_i); while (!quat_ch.ready);
  endtask

  // Component: zero, exactly plus or minus one, uniform in [-1, 1], or a full-range value.
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'sd0;
      2:       return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
      default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  // Output-side stalls: random bursts, none during the quiet tail.
  initial begin
    euler_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        euler_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(posedge clk_i);
      end else begin
        euler_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int tail;
    quiet = 1'b0;
    quat_ch.valid          = 1'b0;
    quat_ch.has_quaternion = 1'b0;
    quat_ch.quat_w         = '0;
    quat_ch.quat_x         = '0;
    quat_ch.quat_y         = '0;
    quat_ch.quat_z         = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, extremes, zero vectors, clamp, x<0 with y=0.
    send_quat(1, 32'h4000_0000, 0, 0, 0);
    send_quat(1, 0, 0, 0, 0);                                     // both yaw atan2 operands zero
    send_quat(0, 32'h1234_5678, 32'h1, 32'h2, 32'h3);             // flag clear
    send_quat(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_quat(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_quat(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_quat(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_quat(1, 32'h2D41_3CCD, 0, 32'h2D41_3CCD, 0);             // pitch +90
    send_quat(1, 32'h2D41_3CCD, 0, 32'hD2BE_C333, 0);             // pitch -90
    send_quat(1, 32'h4000_0000, 0, 32'h4000_0000, 0);             // asin clamp high
    send_quat(1, 32'h4000_0000, 0, 32'hC000_0000, 0);             // asin clamp low
    send_quat(1, 0, 32'h4000_0000, 0, 0);                         // roll at +pi
    send_quat(1, 0, 0, 0, 32'h4000_0000);                         // yaw at +pi
    send_quat(1, 0, 0, 32'h4000_0000, 0);
    send_quat(1, 32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0);
    send_quat(1, 32'h2D41_3CCD, 0, 0, 32'hD2BE_C333);
    send_quat(1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_quat(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems - QuietTail) quiet = 1'b1;
      send_quat($urandom_range(0, 9) != 0, pick_comp(), pick_comp(), pick_comp(),
                pick_comp());
    end
    quat_ch.valid <= 1'b0;

    tail = 0;
    while (pending != 0 && tail < 20000) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/qte_pkg.sv
rtl/qte_if.sv
rtl/qte_front.sv
rtl/qte_cordic.sv
rtl/qte_back.sv
rtl/quaternion_to_euler_angles_core.sv
tb/qte_angle_checker.sv
tb/quaternion_to_euler_angles_core_tb.sv
